@@ rtl/core/php_pkg.sv @@
// Shared types and constants of the private-stream PES header parser.
package php_pkg;

    // Field widths of one input byte and one result.
    localparam int unsigned DATA_W    = 8;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned TS_W      = 33;
    localparam int unsigned OFFSET_W  = 9;
    localparam int unsigned DHL_W     = 4;

    // Packed stream widths, data padded to whole bytes.
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned S_TUSER_W = 1;
    localparam int unsigned M_FIELD_W = TS_W + 2 * OFFSET_W;
    localparam int unsigned M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;
    localparam int unsigned M_TUSER_W = STATUS_W + 1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_START = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_ID    = 2'd2;

    // Start code and stream id values.
    localparam logic [DATA_W-1:0] START_ZERO = 8'h00;
    localparam logic [DATA_W-1:0] START_ONE  = 8'h01;
    localparam logic [DATA_W-1:0] SID_BD     = 8'hBD;
    localparam logic [DATA_W-1:0] SID_BF     = 8'hBF;

    // Header byte positions within the packet.
    localparam logic [OFFSET_W-1:0] POS_SID      = 9'd3;
    localparam logic [OFFSET_W-1:0] POS_BF_DATA  = 9'd6;
    localparam logic [OFFSET_W-1:0] POS_FLAGS    = 9'd7;
    localparam logic [OFFSET_W-1:0] POS_HDL      = 9'd8;
    localparam logic [OFFSET_W-1:0] POS_BD_DATA  = 9'd9;
    localparam logic [OFFSET_W-1:0] POS_PTS_LAST = 9'd13;

    // One parse result.
    typedef struct packed {
        logic [OFFSET_W-1:0] data_offset;
        logic [OFFSET_W-1:0] payload_offset;
        logic [TS_W-1:0]     timestamp;
        logic                is_stream_bf;
        logic [STATUS_W-1:0] status;
    } t_php_result;

endpackage

@@ rtl/core/php_core.sv @@
// Header parse state and the per-byte decision logic.
module php_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_go,
    input  logic [php_pkg::DATA_W-1:0] i_byte,
    input  logic                       i_first,
    output logic                       o_res_valid,
    output php_pkg::t_php_result       o_res
);
    import php_pkg::*;

    logic [OFFSET_W-1:0] r_idx, n_idx, e_idx;
    logic                r_done, n_done, e_done;
    logic                r_bf, n_bf;
    logic                r_pts, n_pts;
    logic [DATA_W-1:0]   r_hdl, n_hdl;
    logic [TS_W-1:0]     r_ptsv, n_ptsv;
    logic [DHL_W-1:0]    r_dhl, n_dhl;

    logic [OFFSET_W-1:0] payload;
    logic [OFFSET_W-1:0] pl2;
    logic [OFFSET_W-1:0] dend;
    logic [OFFSET_W-1:0] fin;

    // Decide on one byte; a first byte restarts from a clean state.
    always_comb begin
        e_idx       = i_first ? '0 : r_idx;
        e_done      = i_first ? 1'b0 : r_done;
        n_idx       = e_idx;
        n_done      = e_done;
        n_bf        = i_first ? 1'b0 : r_bf;
        n_pts       = i_first ? 1'b0 : r_pts;
        n_hdl       = i_first ? '0 : r_hdl;
        n_ptsv      = i_first ? '0 : r_ptsv;
        n_dhl       = i_first ? '0 : r_dhl;
        payload     = '0;
        pl2         = '0;
        dend        = '0;
        fin         = '0;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_go && !e_done) begin
            if ((e_idx <= 9'd1 && i_byte != START_ZERO) ||
                (e_idx == 9'd2 && i_byte != START_ONE)) begin
                o_res_valid  = 1'b1;
                o_res.status = ST_BAD_START;
                n_done       = 1'b1;
            end else if (e_idx == POS_SID && i_byte != SID_BF && i_byte != SID_BD) begin
                o_res_valid  = 1'b1;
                o_res.status = ST_BAD_ID;
                n_done       = 1'b1;
            end else begin
                if (e_idx == POS_SID && i_byte == SID_BF) begin
                    n_bf = 1'b1;
                end
                // Optional header fields of stream 0xBD.
                if (!n_bf) begin
                    if (e_idx == POS_FLAGS) begin
                        n_pts = (i_byte[7:6] == 2'b10);
                    end
                    if (e_idx == POS_HDL) begin
                        n_hdl = i_byte;
                    end
                    if (n_pts) begin
                        case (e_idx)
                            9'd9:  n_ptsv[32:30] = i_byte[3:1];
                            9'd10: n_ptsv[29:22] = i_byte;
                            9'd11: n_ptsv[21:15] = i_byte[7:1];
                            9'd12: n_ptsv[14:7]  = i_byte;
                            9'd13: n_ptsv[6:0]   = i_byte[7:1];
                            default: ;
                        endcase
                    end
                end
                // Payload, data header length and the closing byte.
                if ((n_bf && e_idx >= POS_BF_DATA) || (!n_bf && e_idx >= POS_BD_DATA)) begin
                    payload = n_bf ? POS_BF_DATA : POS_BD_DATA + {1'b0, n_hdl};
                    pl2     = payload + 9'd2;
                    if (e_idx == pl2) begin
                        n_dhl = i_byte[DHL_W-1:0];
                    end
                    dend = pl2 + {5'b0, n_dhl};
                    fin  = (n_pts && dend < POS_PTS_LAST) ? POS_PTS_LAST : dend;
                    if (e_idx >= pl2 && e_idx == fin) begin
                        o_res_valid          = 1'b1;
                        o_res.status         = ST_OK;
                        o_res.is_stream_bf   = n_bf;
                        o_res.timestamp      = n_pts ? n_ptsv : '0;
                        o_res.payload_offset = payload;
                        o_res.data_offset    = dend + 9'd1;
                        n_done               = 1'b1;
                    end
                end
                if (!o_res_valid) begin
                    n_idx = e_idx + 9'd1;
                end
            end
        end
    end

    // State registers load only when a byte is processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_done <= 1'b1;
            r_bf   <= 1'b0;
            r_pts  <= 1'b0;
            r_hdl  <= '0;
            r_ptsv <= '0;
            r_dhl  <= '0;
        end else if (i_go) begin
            r_idx  <= n_idx;
            r_done <= n_done;
            r_bf   <= n_bf;
            r_pts  <= n_pts;
            r_hdl  <= n_hdl;
            r_ptsv <= n_ptsv;
            r_dhl  <= n_dhl;
        end
    end

endmodule

@@ rtl/core/pes_private_header_parser.sv @@
// Top level of the private-stream PES header parser with input and result registers.
// A result passes through the input register, then the result register, to the output.
// Throughput: one byte per cycle through the parse step in php_core, unless the output stalls with both registers full.
// A result waiting on the output does not block input until the input register is also full.
// Reset (synchronous, active low) empties both registers and leaves the parser idle
// until a byte marked as first arrives.
module pes_private_header_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [php_pkg::S_TDATA_W-1:0] i_s_tdata,  // [7:0] data_byte
    input  logic [php_pkg::S_TUSER_W-1:0] i_s_tuser,  // [0] first_byte
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [php_pkg::M_TDATA_W-1:0] o_m_tdata,  // [32:0] timestamp, [41:33] payload_offset,
                                                      // [50:42] data_offset, [55:51] zero
    output logic [php_pkg::M_TUSER_W-1:0] o_m_tuser   // [1:0] status, [2] is_stream_bf
);
    import php_pkg::*;

    logic              r_in_valid;
    logic [DATA_W-1:0] r_in_byte;
    logic              r_in_first;
    logic              r_out_valid;
    t_php_result       r_out;
    logic              advance;
    logic              res_valid;
    t_php_result       res;

    // The input register moves on whenever the result register can take a result.
    assign advance    = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte  <= i_s_tdata[DATA_W-1:0];
            r_in_first <= i_s_tuser[0];
        end
    end

    php_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (r_in_valid && advance),
        .i_byte      (r_in_byte),
        .i_first     (r_in_first),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_TDATA_W - M_FIELD_W){1'b0}},
                         r_out.data_offset, r_out.payload_offset, r_out.timestamp};
    assign o_m_tuser  = {r_out.is_stream_bf, r_out.status};

endmodule

@@ bench/pes_private_header_parser_test.sv @@
// Self-checking testbench for the private-stream PES header parser.
module pes_private_header_parser_test;

    import php_pkg::*;

    // PTS_DTS_flags value that announces a PTS only.
    localparam logic [1:0] PTS_ONLY = 2'b10;
    // The PES data header length sits in the low nibble of this payload byte.
    localparam int DHL_BYTE = 2;
    // Length of the long output hold-off, in cycles.
    localparam int HOLD_OFF_CYCLES = 300;
    // Meaningful bytes of random stimulus in each idling phase.
    localparam int PHASE_BYTES = 250;
    localparam int NUM_PHASES = 5;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              first;
    } t_pes_byte;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;  // [7:0] data_byte
    logic [S_TUSER_W-1:0] s_tuser = '0;  // [0] first_byte
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;       // [32:0] timestamp, [41:33] payload_offset,
                                         // [50:42] data_offset
    logic [M_TUSER_W-1:0] m_tuser;       // [1:0] status, [2] is_stream_bf

    // Bytes waiting to be sent and parse results still owed by the block.
    t_pes_byte   byte_stream[$];
    t_php_result pending_results[$];

    // Idling percentages of the current phase and the long hold-off control.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    // Run statistics.
    int bytes_accepted = 0;
    int results_checked = 0;
    int mismatch_count = 0;
    int held_input_cycles = 0;
    int status_seen[3] = '{0, 0, 0};

    // Parser state as predicted by the testbench.
    logic [OFFSET_W-1:0] pkt_pos = '0;
    bit                  pkt_idle = 1'b1;
    bit                  pkt_is_bf = 1'b0;
    bit                  pts_flag = 1'b0;
    logic [7:0]          pes_hdr_len = '0;
    logic [TS_W-1:0]     pts_acc = '0;
    logic [DHL_W-1:0]    data_hdr_len = '0;

    pes_private_header_parser i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Records the result of the current packet and returns the parser to idle.
    function automatic void record_result(input logic [STATUS_W-1:0] status, input bit is_bf,
                                          input logic [TS_W-1:0] ts, input int payload,
                                          input int data_off);
        t_php_result r;
        r.status         = status;
        r.is_stream_bf   = is_bf;
        r.timestamp      = ts;
        r.payload_offset = OFFSET_W'(payload);
        r.data_offset    = OFFSET_W'(data_off);
        pending_results.push_back(r);
        pkt_idle = 1'b1;
    endfunction

    // Advances the predicted parser by one accepted byte.
    function automatic void parse_pes_byte(input logic [DATA_W-1:0] b, input logic first);
        int pos;
        int payload;
        int dend;
        int last_pos;
        if (first) begin
            pkt_pos      = '0;
            pkt_idle     = 1'b0;
            pkt_is_bf    = 1'b0;
            pts_flag     = 1'b0;
            pes_hdr_len  = '0;
            pts_acc      = '0;
            data_hdr_len = '0;
        end
        if (pkt_idle)
            return;
        pos = int'(pkt_pos);

        // Start code and stream id.
        if ((pos <= 1 && b != START_ZERO) || (pos == 2 && b != START_ONE)) begin
            record_result(ST_BAD_START, 1'b0, '0, 0, 0);
            return;
        end
        if (pos == int'(POS_SID)) begin
            if (b == SID_BF) begin
                pkt_is_bf = 1'b1;
            end else if (b != SID_BD) begin
                record_result(ST_BAD_ID, 1'b0, '0, 0, 0);
                return;
            end
        end

        // Optional header fields and the PTS of a 0xBD stream.
        if (!pkt_is_bf) begin
            if (pos == int'(POS_FLAGS))
                pts_flag = (b[7:6] == PTS_ONLY);
            if (pos == int'(POS_HDL))
                pes_hdr_len = b;
            if (pts_flag) begin
                if (pos == int'(POS_BD_DATA))
                    pts_acc[32:30] = b[3:1];
                else if (pos == int'(POS_BD_DATA) + 1)
                    pts_acc[29:22] = b;
                else if (pos == int'(POS_BD_DATA) + 2)
                    pts_acc[21:15] = b[7:1];
                else if (pos == int'(POS_BD_DATA) + 3)
                    pts_acc[14:7] = b;
                else if (pos == int'(POS_PTS_LAST))
                    pts_acc[6:0] = b[7:1];
            end
        end

        // Payload, data header length and the end of the whole header.
        if ((pkt_is_bf && pos >= int'(POS_BF_DATA)) || (!pkt_is_bf && pos >= int'(POS_BD_DATA)))
        begin
            payload = pkt_is_bf ? int'(POS_BF_DATA) : int'(POS_BD_DATA) + int'(pes_hdr_len);
            if (pos == payload + DHL_BYTE)
                data_hdr_len = b[DHL_W-1:0];
            if (pos >= payload + DHL_BYTE) begin
                dend = payload + DHL_BYTE + int'(data_hdr_len);
                last_pos = dend;
                // With a PTS the result waits until the timestamp is complete.
                if (pts_flag && last_pos < int'(POS_PTS_LAST))
                    last_pos = int'(POS_PTS_LAST);
                if (pos == last_pos) begin
                    record_result(ST_OK, pkt_is_bf, pts_flag ? pts_acc : '0, payload, dend + 1);
                    return;
                end
            end
        end
        pkt_pos = pkt_pos + 1'b1;
    endfunction

    function automatic void queue_byte(input logic [DATA_W-1:0] b, input logic first);
        t_pes_byte item;
        item.data  = b;
        item.first = first;
        byte_stream.push_back(item);
    endfunction

    // Queues a well-formed packet, cut short when cut is below its header length.
    function automatic int queue_good_packet(input bit is_bf, input logic [1:0] flags,
                                             input int hdl, input logic [DHL_W-1:0] dhl,
                                             input int cut);
        int payload;
        int len;
        int pts_mode;
        logic [DATA_W-1:0] b;
        payload = is_bf ? int'(POS_BF_DATA) : int'(POS_BD_DATA) + hdl;
        len = payload + DHL_BYTE + 1 + int'(dhl);
        if (!is_bf && flags == PTS_ONLY && len <= int'(POS_PTS_LAST))
            len = int'(POS_PTS_LAST) + 1;
        if (cut > 0 && cut < len)
            len = cut;
        // Now and then the timestamp bytes are all zeros or all ones.
        pts_mode = $urandom_range(7);
        for (int n = 0; n < len; n++) begin
            b = DATA_W'($urandom);
            if (n <= 1)
                b = START_ZERO;
            else if (n == 2)
                b = START_ONE;
            else if (n == int'(POS_SID))
                b = is_bf ? SID_BF : SID_BD;
            else if (!is_bf && n == int'(POS_FLAGS))
                b[7:6] = flags;
            else if (!is_bf && n == int'(POS_HDL))
                b = DATA_W'(hdl);
            else if (!is_bf && n >= int'(POS_BD_DATA) && n <= int'(POS_PTS_LAST) && pts_mode < 2)
                b = (pts_mode == 1) ? 8'hFF : 8'h00;
            if (n == payload + DHL_BYTE)
                b[DHL_W-1:0] = dhl;
            queue_byte(b, n == 0);
        end
        return len;
    endfunction

    // Queues one random packet and returns the number of bytes the parser acts on.
    function automatic int queue_random_packet();
        int sel;
        int count;
        int err_pos;
        bit is_bf;
        logic [1:0] flags;
        int hdl;
        logic [DATA_W-1:0] b;
        sel = $urandom_range(99);
        is_bf = ($urandom_range(3) == 0);
        flags = $urandom_range(1) ? PTS_ONLY : 2'($urandom);
        hdl = ($urandom_range(59) == 0) ? $urandom_range(200, 255) : $urandom_range(0, 12);
        count = 0;
        if (sel < 70) begin
            count = queue_good_packet(is_bf, flags, hdl, DHL_W'($urandom), 0);
            // Trailing bytes after the result are ignored.
            repeat ($urandom_range(0, 3)) queue_byte(DATA_W'($urandom), 1'b0);
        end else if (sel < 80) begin
            err_pos = $urandom_range(2);
            for (int n = 0; n < err_pos; n++)
                queue_byte(START_ZERO, n == 0);
            if (err_pos < 2)
                b = DATA_W'($urandom_range(1, 255));
            else
                do b = DATA_W'($urandom); while (b == START_ONE);
            queue_byte(b, err_pos == 0);
            count = err_pos + 1;
        end else if (sel < 88) begin
            queue_byte(START_ZERO, 1'b1);
            queue_byte(START_ZERO, 1'b0);
            queue_byte(START_ONE, 1'b0);
            do b = DATA_W'($urandom); while (b == SID_BD || b == SID_BF);
            queue_byte(b, 1'b0);
            count = 4;
        end else if (sel < 96) begin
            // Broken packet: the next first byte restarts the parser mid-header.
            count = queue_good_packet(is_bf, flags, hdl, DHL_W'($urandom),
                                      $urandom_range(1, 20));
        end else begin
            repeat ($urandom_range(1, 4)) queue_byte(DATA_W'($urandom), 1'b0);
        end
        return count;
    endfunction

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("Mismatch in %s of result %0d: expected 0x%0h, got 0x%0h",
                         name, results_checked, want, got);
        end
    endfunction

    // Sender: offers queued bytes, idling at random.
    always @(posedge i_clk) begin : sender
        t_pes_byte item;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (byte_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                item = byte_stream.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= item.data;
                s_tuser  <= item.first;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Long output hold-off, counted here once it has been asked for.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            hold_left <= HOLD_OFF_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Receiver: stalls at random and throughout the hold-off.
    always @(posedge i_clk) begin
        m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: predicts each accepted byte, then checks each accepted result.
    always @(posedge i_clk) begin : monitor
        t_php_result got;
        t_php_result want;
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                parse_pes_byte(s_tdata, s_tuser[0]);
                bytes_accepted++;
            end
            if (hold_left != 0 && s_tvalid && !s_tready)
                held_input_cycles++;
            if (m_tvalid && m_tready) begin
                got.status         = m_tuser[STATUS_W-1:0];
                got.is_stream_bf   = m_tuser[STATUS_W];
                got.timestamp      = m_tdata[TS_W-1:0];
                got.payload_offset = m_tdata[TS_W +: OFFSET_W];
                got.data_offset    = m_tdata[TS_W + OFFSET_W +: OFFSET_W];
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Unexpected result: status %0d, timestamp 0x%0h",
                                 got.status, got.timestamp);
                end else begin
                    want = pending_results.pop_front();
                    compare_field("status", 64'(want.status), 64'(got.status));
                    compare_field("is_stream_bf", 64'(want.is_stream_bf), 64'(got.is_stream_bf));
                    compare_field("timestamp", 64'(want.timestamp), 64'(got.timestamp));
                    compare_field("payload_offset", 64'(want.payload_offset),
                                  64'(got.payload_offset));
                    compare_field("data_offset", 64'(want.data_offset), 64'(got.data_offset));
                    if (want.status <= ST_BAD_ID)
                        status_seen[want.status]++;
                    results_checked++;
                end
            end
        end
    end

    task automatic wait_drained();
        while (byte_stream.size() != 0 || s_tvalid || pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    // Stimulus: directed packets, then random phases with different idling.
    initial begin : stimulus
        int budget;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // A stray byte while idle, a bad first byte, a restart mid-header that ends
        // in a rejected stream id, then a short 0xBD header whose PTS overlaps the payload.
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b1);
        queue_byte(START_ZERO, 1'b1);
        queue_byte(START_ZERO, 1'b0);
        queue_byte(START_ZERO, 1'b1);
        queue_byte(START_ZERO, 1'b0);
        queue_byte(START_ONE, 1'b0);
        queue_byte(8'h00, 1'b0);
        void'(queue_good_packet(1'b0, PTS_ONLY, 0, '0, 0));
        wait_drained();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            @(negedge i_clk);
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
                3: begin send_idle_pct = 15; recv_stall_pct = 15; end
                default: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                    hold_req = 1'b1;
                end
            endcase
            budget = 0;
            if (phase == 0) begin
                // Longest possible header, then the longest 0xBF header.
                budget += queue_good_packet(1'b0, PTS_ONLY, 255, 4'hF, 0);
                budget += queue_good_packet(1'b1, 2'b00, 0, 4'hF, 0);
            end
            while (budget < PHASE_BYTES)
                budget += queue_random_packet();
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        $display("Covered %0d bytes, %0d results: %0d parsed, %0d bad start, %0d bad id.",
                 bytes_accepted, results_checked, status_seen[0], status_seen[1], status_seen[2]);
        $display("Input held back for %0d cycles during the output hold-off; %0d mismatches.",
                 held_input_cycles, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("** pes_private_header_parser: PASSED **");
        else
            $display("** pes_private_header_parser: FAILED **");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #2000000;
        $display("Timeout with %0d results outstanding.", pending_results.size());
        $display("** pes_private_header_parser: FAILED **");
        $finish;
    end

endmodule
